@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied
`define PLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the following clock edge
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/plsch_pkg.sv @@
// Package: constants, command and status types of the latency scheduler
`timescale 1ns / 1ps

package plsch_pkg;

    localparam int MAX_WIDTH = 20;
    localparam int MAX_TASKS = 10;
    localparam int UNITS     = 5;
    localparam int OCC_DEPTH = 256;

    localparam int MASK_W  = 20;
    localparam int WIDTH_W = 5;
    localparam int CNT_W   = 4;
    localparam int TIME_W  = 8;
    localparam int OCC_AW  = 8;
    localparam int LAT_W   = 5;
    localparam int IDX_W   = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_UNIT0       = 3'd0;
    localparam logic [IDX_W-1:0] REG_UNIT1       = 3'd1;
    localparam logic [IDX_W-1:0] REG_UNIT2       = 3'd2;
    localparam logic [IDX_W-1:0] REG_UNIT3       = 3'd3;
    localparam logic [IDX_W-1:0] REG_UNIT4       = 3'd4;
    localparam logic [IDX_W-1:0] REG_TABLE_WIDTH = 3'd5;

    typedef enum logic [1:0] {
        WALK_FIT,
        WALK_SET,
        WALK_CLR
    } walk_op_t;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_LAT,
        BASE_NC,
        BASE_TOP
    } base_sel_t;

    typedef struct packed {
        logic      load;
        logic      clr_step;
        logic      walk_start;
        walk_op_t  walk_op;
        base_sel_t base_sel;
        logic      lat_step;
        logic      k_init;
        logic      best_upd;
        logic      push;
        logic      idx_inc;
        logic      pop;
        logic      bound_wr;
        logic      out_load;
    } plsch_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic walk_fit;
        logic lat_last;
        logic k_last;
        logic sp_ge_k;
        logic idx_end;
        logic prune;
        logic sp_is_one;
    } plsch_stat_t;

endpackage

@@ hw/rtl/pipeline_latency_scheduler.sv @@
// Top level: reservation-table latency scheduler
// Per item: the occupancy memory is cleared over all 256 entries, then a column
// walk over the W columns (W = table width) runs for the latency list and for every
// tried placement of the branch-and-bound search; the run time is data dependent.
// One item at a time; the next is taken once the search has finished.
// rst_n asynchronous active low: configuration returns to empty masks, width 1.
`timescale 1ns / 1ps

module pipeline_latency_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [3:0] task_count, [7:4] zero
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [7:0] min_time
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [plsch_pkg::IDX_W-1:0]  cfg_index,
    input  logic [plsch_pkg::MASK_W-1:0] cfg_data
);
    import plsch_pkg::*;

    plsch_cmd_t  cmd;
    plsch_stat_t stat;

    assign cfg_ready = 1'b1;

    plsch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    plsch_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .task_count (s_axis_tdata[CNT_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .min_time   (m_axis_tdata)
    );

endmodule

@@ hw/rtl/plsch_ctrl.sv @@
// Controller: sequences clearing, latency listing and the branch-and-bound search
`timescale 1ns / 1ps

module plsch_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  plsch_pkg::plsch_stat_t stat,
    output plsch_pkg::plsch_cmd_t  cmd
);
    import plsch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SET0,
        S_LAT_ISSUE,
        S_LAT_WAIT,
        S_KINIT,
        S_STEP,
        S_FIT_WAIT,
        S_SET_WAIT,
        S_CLR_WAIT,
        S_BOUND,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_op    = WALK_SET;
                    cmd.base_sel   = BASE_ZERO;
                    state_next     = S_SET0;
                end
            end
            S_SET0:
            begin
                if (stat.walk_done)
                    state_next = S_LAT_ISSUE;
            end
            S_LAT_ISSUE:
            begin
                cmd.walk_start = 1'b1;
                cmd.walk_op    = WALK_FIT;
                cmd.base_sel   = BASE_LAT;
                state_next     = S_LAT_WAIT;
            end
            S_LAT_WAIT:
            begin
                if (stat.walk_done)
                begin
                    cmd.lat_step = 1'b1;
                    state_next   = stat.lat_last ? S_KINIT : S_LAT_ISSUE;
                end
            end
            S_KINIT:
            begin
                cmd.k_init = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (stat.sp_ge_k || stat.idx_end || stat.prune)
                begin
                    // backtrack: drop the top task, release its cells unless it is the first one
                    cmd.best_upd = stat.sp_ge_k;
                    cmd.pop      = 1'b1;
                    if (stat.sp_is_one)
                        state_next = S_BOUND;
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_op    = WALK_CLR;
                        cmd.base_sel   = BASE_TOP;
                        state_next     = S_CLR_WAIT;
                    end
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_op    = WALK_FIT;
                    cmd.base_sel   = BASE_NC;
                    state_next     = S_FIT_WAIT;
                end
            end
            S_FIT_WAIT:
            begin
                if (stat.walk_done)
                begin
                    if (stat.walk_fit)
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_op    = WALK_SET;
                        cmd.base_sel   = BASE_NC;
                        state_next     = S_SET_WAIT;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_STEP;
                    end
                end
            end
            S_SET_WAIT:
            begin
                if (stat.walk_done)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_CLR_WAIT:
            begin
                if (stat.walk_done)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_BOUND:
            begin
                cmd.bound_wr = 1'b1;
                state_next   = stat.k_last ? S_DONE : S_KINIT;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/plsch_dp.sv @@
// Datapath: configuration, occupancy memory, search stacks and bound table
`timescale 1ns / 1ps

module plsch_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [plsch_pkg::IDX_W-1:0]   cfg_index,
    input  logic [plsch_pkg::MASK_W-1:0]  cfg_data,
    input  logic [plsch_pkg::CNT_W-1:0]   task_count,
    input  plsch_pkg::plsch_cmd_t         cmd,
    output plsch_pkg::plsch_stat_t        stat,
    output logic [plsch_pkg::TIME_W-1:0]  min_time
);
    import plsch_pkg::*;

    // Configuration
    logic [MASK_W-1:0]  mask_reg [UNITS];
    logic [WIDTH_W-1:0] width_reg;

    // Per-request control
    logic [CNT_W-1:0]   n_reg;
    logic [WIDTH_W-1:0] w_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   sp_reg;
    logic [TIME_W-1:0]  best_reg;
    logic [OCC_AW-1:0]  clr_addr_reg;
    logic [LAT_W-1:0]   lat_i_reg;
    logic [LAT_W-1:0]   lat_cnt_reg;

    // Storage without reset
    logic [UNITS-1:0]   colu_reg    [MAX_WIDTH];
    logic [LAT_W-1:0]   latlist_reg [MAX_WIDTH+1];
    logic [TIME_W-1:0]  start_reg   [MAX_TASKS];
    logic [LAT_W-1:0]   lidx_reg    [MAX_TASKS+1];
    logic [TIME_W-1:0]  bound_reg   [MAX_TASKS+1];
    logic [TIME_W-1:0]  out_data_reg;

    // Walk unit over the columns of one task
    logic               wk_busy_reg;
    logic               wk_phase_reg;
    logic [WIDTH_W-1:0] wk_c_reg;
    logic [OCC_AW-1:0]  wk_base_reg;
    walk_op_t           wk_op_reg;
    logic               wk_fit_reg;

    logic [UNITS-1:0]   occ_mem [OCC_DEPTH];
    logic [UNITS-1:0]   rd_data_reg;

    logic [CNT_W-1:0]   n_clamp;
    logic [WIDTH_W-1:0] w_clamp;
    logic [OCC_AW-1:0]  wk_addr;
    logic [UNITS-1:0]   col_now;
    logic               hit;
    logic               fit_now;
    logic               walk_done;
    logic               mem_we;
    logic [OCC_AW-1:0]  mem_waddr;
    logic [UNITS-1:0]   mem_wdata;
    logic [LAT_W-1:0]   idx_cur;
    logic [TIME_W-1:0]  top_start;
    logic [TIME_W:0]    nc;
    logic [TIME_W+1:0]  nc_bound;
    logic [OCC_AW-1:0]  base_pick;
    logic [TIME_W:0]    fin;
    logic [WIDTH_W+CNT_W-1:0] best_init;

    // Clamp request and width into range
    always_comb
    begin
        if (task_count == '0)
            n_clamp = CNT_W'(1);
        else if (task_count > CNT_W'(MAX_TASKS))
            n_clamp = CNT_W'(MAX_TASKS);
        else
            n_clamp = task_count;
        if (width_reg == '0)
            w_clamp = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w_clamp = WIDTH_W'(MAX_WIDTH);
        else
            w_clamp = width_reg;
    end

    // Walk datapath
    assign wk_addr   = wk_base_reg + OCC_AW'(wk_c_reg);
    assign col_now   = colu_reg[wk_c_reg];
    assign hit       = |(rd_data_reg & col_now);
    assign fit_now   = wk_fit_reg & ~hit;
    assign walk_done = wk_busy_reg & wk_phase_reg & (wk_c_reg == w_reg - WIDTH_W'(1));

    // Memory write port: clearing pass or walk update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wk_addr;
        mem_wdata = rd_data_reg | col_now;
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (wk_busy_reg && wk_phase_reg && wk_op_reg != WALK_FIT)
        begin
            mem_we = 1'b1;
            if (wk_op_reg == WALK_CLR)
                mem_wdata = rd_data_reg & ~col_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            occ_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= occ_mem[wk_addr];
    end

    // Search arithmetic
    assign idx_cur   = lidx_reg[sp_reg];
    assign top_start = start_reg[sp_reg - CNT_W'(1)];
    assign nc        = {1'b0, top_start} + (TIME_W+1)'(latlist_reg[idx_cur]);
    assign nc_bound  = {1'b0, nc} + (TIME_W+2)'(bound_reg[k_reg - sp_reg]);
    assign fin       = {1'b0, top_start} + (TIME_W+1)'(w_reg);
    assign best_init = w_reg * k_reg;

    always_comb
    begin
        case (cmd.base_sel)
            BASE_ZERO: base_pick = '0;
            BASE_LAT:  base_pick = OCC_AW'(lat_i_reg);
            BASE_NC:   base_pick = nc[OCC_AW-1:0];
            BASE_TOP:  base_pick = top_start;
            default:   base_pick = '0;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        stat.clr_last  = (clr_addr_reg == OCC_AW'(OCC_DEPTH - 1));
        stat.walk_done = walk_done;
        stat.walk_fit  = fit_now;
        stat.lat_last  = (lat_i_reg == w_reg);
        stat.k_last    = (k_reg == n_reg);
        stat.sp_ge_k   = (sp_reg >= k_reg);
        stat.idx_end   = (idx_cur >= lat_cnt_reg);
        stat.prune     = (nc_bound >= (TIME_W+2)'(best_reg));
        stat.sp_is_one = (sp_reg == CNT_W'(1));
    end

    assign min_time = out_data_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < UNITS; u++)
                mask_reg[u] <= '0;
            width_reg    <= WIDTH_W'(1);
            n_reg        <= CNT_W'(1);
            w_reg        <= WIDTH_W'(1);
            k_reg        <= CNT_W'(1);
            sp_reg       <= '0;
            best_reg     <= '0;
            clr_addr_reg <= '0;
            lat_i_reg    <= '0;
            lat_cnt_reg  <= '0;
            wk_busy_reg  <= 1'b0;
            wk_phase_reg <= 1'b0;
            wk_c_reg     <= '0;
            wk_base_reg  <= '0;
            wk_op_reg    <= WALK_FIT;
            wk_fit_reg   <= 1'b0;
        end
        else
        begin
            // configuration transaction
            if (cfg_we)
            begin
                if (cfg_index < REG_TABLE_WIDTH)
                    mask_reg[cfg_index - REG_UNIT0] <= cfg_data;
                else if (cfg_index == REG_TABLE_WIDTH)
                    width_reg <= cfg_data[WIDTH_W-1:0];
            end

            if (cmd.load)
            begin
                n_reg        <= n_clamp;
                w_reg        <= w_clamp;
                k_reg        <= CNT_W'(1);
                clr_addr_reg <= '0;
                lat_i_reg    <= '0;
                lat_cnt_reg  <= '0;
            end

            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + OCC_AW'(1);

            // walk sequencing: read a column, then test or update it
            if (cmd.walk_start)
            begin
                wk_busy_reg  <= 1'b1;
                wk_phase_reg <= 1'b0;
                wk_c_reg     <= '0;
                wk_base_reg  <= base_pick;
                wk_op_reg    <= cmd.walk_op;
                wk_fit_reg   <= 1'b1;
            end
            else if (wk_busy_reg)
            begin
                if (!wk_phase_reg)
                    wk_phase_reg <= 1'b1;
                else
                begin
                    wk_phase_reg <= 1'b0;
                    wk_fit_reg   <= fit_now;
                    if (walk_done)
                        wk_busy_reg <= 1'b0;
                    else
                        wk_c_reg <= wk_c_reg + WIDTH_W'(1);
                end
            end

            if (cmd.lat_step)
            begin
                lat_i_reg <= lat_i_reg + LAT_W'(1);
                if (fit_now)
                    lat_cnt_reg <= lat_cnt_reg + LAT_W'(1);
            end

            if (cmd.k_init)
            begin
                best_reg <= best_init[TIME_W-1:0];
                sp_reg   <= CNT_W'(1);
            end

            if (cmd.best_upd && fin < (TIME_W+1)'(best_reg))
                best_reg <= fin[TIME_W-1:0];

            if (cmd.push)
                sp_reg <= sp_reg + CNT_W'(1);
            if (cmd.pop)
                sp_reg <= sp_reg - CNT_W'(1);

            if (cmd.bound_wr && !stat.k_last)
                k_reg <= k_reg + CNT_W'(1);
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int c = 0; c < MAX_WIDTH; c++)
                for (int u = 0; u < UNITS; u++)
                    colu_reg[c][u] <= mask_reg[u][c];
            bound_reg[0] <= '0;
        end
        if (cmd.lat_step && fit_now)
            latlist_reg[lat_cnt_reg] <= lat_i_reg;
        if (cmd.k_init)
        begin
            start_reg[0] <= '0;
            lidx_reg[1]  <= '0;
        end
        if (cmd.push)
        begin
            start_reg[sp_reg]            <= nc[TIME_W-1:0];
            lidx_reg[sp_reg + CNT_W'(1)] <= '0;
        end
        if (cmd.idx_inc)
            lidx_reg[sp_reg] <= idx_cur + LAT_W'(1);
        if (cmd.bound_wr)
            bound_reg[k_reg] <= best_reg;
        if (cmd.out_load)
            out_data_reg <= best_reg;
    end

endmodule

@@ hw/rtl/plsch_checker.sv @@
// Port-level checker for the latency scheduler, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plsch_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // held result must not change while stalled
    `PLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // one item in flight: input closes after a transaction
    `PLS_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still open after a transaction")

    // finish time is nonzero: it is at least one table width
    `PLS_ASSERT(a_nonzero, m_axis_tvalid |-> (m_axis_tdata != 8'd0), "zero finish time")

endmodule

bind pipeline_latency_scheduler plsch_checker u_plsch_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
